// ===== sv/rle_pkg.sv =====
// ----------------------------------------------------------------------------
// rle_pkg: shared types and codes for the ring leader election node
// Message, action, status and port codes, plus the queued result record.
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam int unsigned IdWidth   = 16;
  localparam int unsigned HopsWidth = 17;
  localparam int unsigned PhaseW    = 5;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  // input actions
  localparam logic [1:0] ActSendBoth = 2'd0;  // start election
  localparam logic [1:0] ActSendPass = 2'd1;  // probe
  localparam logic [1:0] ActSendEcho = 2'd2;  // echo
  localparam logic [1:0] ActLeader   = 2'd3;  // leader announce

  // outgoing message kinds
  localparam logic [1:0] KindProbe  = 2'd0;
  localparam logic [1:0] KindEcho   = 2'd1;
  localparam logic [1:0] KindLeader = 2'd2;

  // election status
  localparam logic [1:0] StCand = 2'd0;
  localparam logic [1:0] StLost = 2'd1;
  localparam logic [1:0] StWon  = 2'd2;

  // neighbour ports and direction labels
  localparam logic PortLeft  = 1'b0;
  localparam logic PortRight = 1'b1;
  localparam logic DirR      = 1'b0;
  localparam logic DirL      = 1'b1;

  // configuration register indexes
  localparam logic CfgNodeId   = 1'b0;
  localparam logic CfgRingSize = 1'b1;

  localparam logic [IdWidth-1:0] RingSizeRst = IdWidth'(2);

  typedef struct packed {
    logic [1:0]           kind;
    logic [IdWidth-1:0]   cand;
    logic [HopsWidth-1:0] hops;
    logic                 dir;
    logic                 port;
    logic [1:0]           status;
    logic                 last;
  } result_t;

endpackage

// ===== sv/ring_leader_election_node.sv =====
// ----------------------------------------------------------------------------
// ring_leader_election_node: one node of a Hirschberg-Sinclair ring
// Decodes start/probe/echo/leader events and queues up to two messages each.
// ----------------------------------------------------------------------------
// Path: an input transfer is captured in the input register, then decision logic
// writes its results into the result queue that feeds the master side.
// Throughput: one item per cycle while each yields at most one message and the master
// side keeps up; the single result port drains one message at a time, so two-message items slow it.
// Reset: node_id 0, ring_size 2, status candidate, phase 0, flags and queue clear.
module ring_leader_election_node
  import rle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input events
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // cand_id[15:0], hops_left[32:16], travel_dir[33]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  // outgoing messages
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // msg_cand[15:0], msg_hops[32:16], msg_dir[33],
                                      // node_status[35:34]
  output logic [2:0]  m_axis_tuser,   // msg_kind[1:0], out_port[2]
  output logic        m_axis_tlast
);

  // configuration
  logic [IdWidth-1:0] node_id_q, ring_size_q;

  // input register
  logic                 in_vld_q;
  logic [1:0]           act_q;
  logic [IdWidth-1:0]   cand_q;
  logic [HopsWidth-1:0] hops_q;
  logic                 dir_q;

  // election state
  logic [1:0]        status_q, status_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              awr_q, awr_d;
  logic              awl_q, awl_d;
  logic              halted_q, halted_d;

  // result queue
  result_t           q_mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q;

  logic              s_xfer, m_xfer, adv;
  logic [1:0]        n_res;
  result_t           r0, r1;
  logic              was_set, big, win_now;
  logic [PhaseW-1:0] phase_inc;
  logic [HopsWidth-1:0] ttl;
  result_t           head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q   <= '0;
      ring_size_q <= RingSizeRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNodeId:   node_id_q   <= cfg_data_i;
        CfgRingSize: ring_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // an item leaves the input register only when the queue can take two results
  assign adv           = in_vld_q && (count_q <= QCntW'(QDepth - 2));
  assign s_axis_tready = !in_vld_q || adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_xfer) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      act_q  <= s_axis_tuser;
      cand_q <= s_axis_tdata[15:0];
      hops_q <= s_axis_tdata[32:16];
      dir_q  <= s_axis_tdata[33];
    end
  end

  always_comb begin
    status_d  = status_q;
    phase_d   = phase_q;
    awr_d     = awr_q;
    awl_d     = awl_q;
    halted_d  = halted_q;
    n_res     = 2'd0;
    r0        = '0;
    r1        = '0;
    was_set   = 1'b0;
    phase_inc = (phase_q == '1) ? phase_q : phase_q + PhaseW'(1);
    big       = phase_inc > PhaseW'(HopsWidth - 1);
    ttl       = big ? '0 : HopsWidth'(1) << phase_inc;
    win_now   = big || (ttl >= {1'b0, ring_size_q});

    if (adv && !halted_q) begin
      unique case (act_q)
        ActSendBoth: begin
          if (status_q == StCand) begin
            phase_d = '0;
            awr_d   = 1'b1;
            awl_d   = 1'b1;
            r0      = '{kind: KindProbe, cand: node_id_q, hops: HopsWidth'(1), dir: DirR,
                        port: PortRight, status: StCand, last: 1'b0};
            r1      = '{kind: KindProbe, cand: node_id_q, hops: HopsWidth'(1), dir: DirL,
                        port: PortLeft, status: StCand, last: 1'b0};
            n_res   = 2'd2;
          end
        end
        ActSendPass: begin
          if (cand_q == node_id_q) begin
            status_d = StWon;
            r0       = '{kind: KindLeader, cand: node_id_q, hops: '0, dir: 1'b0,
                         port: PortRight, status: StWon, last: 1'b0};
            n_res    = 2'd1;
          end else if (cand_q > node_id_q) begin
            if (status_q == StCand) status_d = StLost;
            if (hops_q > HopsWidth'(1)) begin
              r0 = '{kind: KindProbe, cand: cand_q, hops: hops_q - HopsWidth'(1),
                     dir: dir_q, port: dir_q ? PortLeft : PortRight,
                     status: StCand, last: 1'b0};
            end else begin
              // ttl spent: turn back toward the origin
              r0 = '{kind: KindEcho, cand: cand_q, hops: '0, dir: dir_q,
                     port: dir_q ? PortRight : PortLeft, status: StCand, last: 1'b0};
            end
            n_res = 2'd1;
          end
        end
        ActSendEcho: begin
          if (cand_q == node_id_q && status_q == StCand) begin
            if (dir_q == DirR) begin
              was_set = awr_q;
              awr_d   = 1'b0;
            end else begin
              was_set = awl_q;
              awl_d   = 1'b0;
            end
            if (was_set && !awr_d && !awl_d) begin
              phase_d = phase_inc;
              if (win_now) begin
                status_d = StWon;
                r0       = '{kind: KindLeader, cand: node_id_q, hops: '0, dir: 1'b0,
                             port: PortRight, status: StWon, last: 1'b0};
                n_res    = 2'd1;
              end else begin
                awr_d = 1'b1;
                awl_d = 1'b1;
                r0    = '{kind: KindProbe, cand: node_id_q, hops: ttl, dir: DirR,
                          port: PortRight, status: StCand, last: 1'b0};
                r1    = '{kind: KindProbe, cand: node_id_q, hops: ttl, dir: DirL,
                          port: PortLeft, status: StCand, last: 1'b0};
                n_res = 2'd2;
              end
            end
          end else begin
            r0    = '{kind: KindEcho, cand: cand_q, hops: '0, dir: dir_q,
                      port: dir_q ? PortRight : PortLeft, status: StCand, last: 1'b0};
            n_res = 2'd1;
          end
        end
        ActLeader: begin
          if (cand_q != node_id_q) begin
            status_d = StLost;
            r0       = '{kind: KindLeader, cand: cand_q, hops: '0, dir: 1'b0,
                         port: PortRight, status: StLost, last: 1'b0};
            n_res    = 2'd1;
          end
          halted_d = 1'b1;
        end
        default: ;
      endcase
    end

    // status after the step goes on every result of the step
    r0.status = status_d;
    r1.status = status_d;
    r0.last   = (n_res == 2'd1);
    r1.last   = (n_res == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= StCand;
      phase_q  <= '0;
      awr_q    <= 1'b0;
      awl_q    <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      status_q <= status_d;
      phase_q  <= phase_d;
      awr_q    <= awr_d;
      awl_q    <= awl_d;
      halted_q <= halted_d;
    end
  end

  // result queue
  assign m_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) q_mem_q[wr_ptr_q] <= r0;
    if (n_res == 2'd2) q_mem_q[wr_ptr_q + QPtrW'(1)] <= r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(n_res);
      if (m_xfer) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      count_q  <= count_q + QCntW'(n_res) - QCntW'(m_xfer);
    end
  end

  assign head          = q_mem_q[rd_ptr_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {4'b0, head.status, head.dir, head.hops, head.cand};
  assign m_axis_tuser  = {head.port, head.kind};
  assign m_axis_tlast  = head.last;

  // assertions
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_no_work_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (n_res == 2'd0) && (status_d == status_q))
    else $error("halted node produced results or changed status");

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("node left halted state");

  a_status_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q != StCand) |=> (status_q != StCand))
    else $error("node returned to candidate");

  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_res == 2'd2) |-> !r0.last && r1.last && (r0.kind == KindProbe))
    else $error("two-result step not a marked probe pair");

endmodule
